// ===== rtl/ctsc_pkg.sv =====
// Shared types, key and field codes, step bounds and helpers for the clock time-set controller.
// No dependencies; used by ctsc_step and clock_time_set_controller.
`timescale 1ns / 1ps

package ctsc_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_BLINK_LIMIT = 2'd0;
	localparam logic [1:0] REG_YEAR_MIN    = 2'd1;
	localparam logic [1:0] REG_YEAR_MAX    = 2'd2;

	localparam logic [7:0]  BLINK_LIMIT_RST = 8'd50;
	localparam logic [11:0] YEAR_MIN_RST    = 12'd2000;
	localparam logic [11:0] YEAR_MAX_RST    = 12'd2099;

	// Key codes
	localparam logic [2:0] KEY_NONE = 3'd0;
	localparam logic [2:0] KEY_UP   = 3'd1;
	localparam logic [2:0] KEY_DN   = 3'd2;
	localparam logic [2:0] KEY_OK   = 3'd3;
	localparam logic [2:0] KEY_ESC  = 3'd4;

	// Field codes
	localparam logic [2:0] FLD_YEAR   = 3'd0;
	localparam logic [2:0] FLD_MONTH  = 3'd1;
	localparam logic [2:0] FLD_DAY    = 3'd2;
	localparam logic [2:0] FLD_HOUR   = 3'd3;
	localparam logic [2:0] FLD_MINUTE = 3'd4;
	localparam logic [2:0] FLD_SECOND = 3'd5;

	localparam logic [11:0] MONTH_MIN  = 12'd1;
	localparam logic [11:0] MONTH_MAX  = 12'd12;
	localparam logic [11:0] DAY_MIN    = 12'd1;
	localparam logic [11:0] DAY_MAX    = 12'd31;
	localparam logic [11:0] HOUR_MIN   = 12'd0;
	localparam logic [11:0] HOUR_MAX   = 12'd23;
	localparam logic [11:0] MINSEC_MIN = 12'd0;
	localparam logic [11:0] MINSEC_MAX = 12'd59;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} time_t;

	typedef struct packed {
		logic [7:0]  blink_limit;
		logic [11:0] year_min;
		logic [11:0] year_max;
	} cfg_t;

	typedef struct packed {
		logic       page_active;
		logic [2:0] kind;
		time_t      rtc;
	} tick_t;

	typedef struct packed {
		time_t      tf;
		logic [2:0] focus;
		logic       edit;
		logic       first;
		logic [7:0] count;
		logic       blink_on;
	} state_t;

	typedef struct packed {
		time_t      tf;
		logic [2:0] selected_field;
		logic       editing;
		logic       highlight_on;
		logic       redraw;
		logic       commit;
	} result_t;

	localparam state_t STATE_RST = '{
		tf:       '0,
		focus:    FLD_YEAR,
		edit:     1'b0,
		first:    1'b1,
		count:    8'd0,
		blink_on: 1'b1
	};

	function automatic logic [2:0] focus_next(input logic [2:0] f);
		return (f >= FLD_SECOND) ? FLD_YEAR : f + 3'd1;
	endfunction

	function automatic logic [2:0] focus_prev(input logic [2:0] f);
		return (f == FLD_YEAR || f > FLD_SECOND) ? FLD_SECOND : f - 3'd1;
	endfunction

	// Wrap at the bounds: at or past max goes to min, at or below min goes to max
	function automatic logic [11:0] step_val(input logic [11:0] v, input logic [11:0] mn,
		input logic [11:0] mx, input logic up);
		logic [11:0] r;
		if (up) begin
			r = (v >= mx) ? mn : v + 12'd1;
		end else begin
			r = (v <= mn) ? mx : v - 12'd1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/ctsc_step.sv =====
// Next-state and result logic for one UI tick of the time-set controller.
// Depends on ctsc_pkg.
`timescale 1ns / 1ps

module ctsc_step (
	input  ctsc_pkg::state_t  st,
	input  ctsc_pkg::tick_t   tick,
	input  ctsc_pkg::cfg_t    cfg,
	output ctsc_pkg::state_t  nxt,
	output ctsc_pkg::result_t res
);

	logic        redraw;
	logic        changed;
	logic        commit;
	logic        do_step;
	logic        step_up;
	logic [11:0] cur_val;
	logic [11:0] mn;
	logic [11:0] mx;
	logic [11:0] stepped;

	always_comb begin
		nxt     = st;
		redraw  = 1'b0;
		changed = 1'b0;
		commit  = 1'b0;
		do_step = 1'b0;
		step_up = 1'b0;
		cur_val = '0;
		mn      = '0;
		mx      = '0;
		stepped = '0;

		if (tick.page_active) begin
			if (st.first) begin
				nxt.tf    = tick.rtc;
				nxt.focus = ctsc_pkg::FLD_YEAR;
				redraw    = 1'b1;
			end

			case (tick.kind)
				ctsc_pkg::KEY_UP: begin
					if (!st.edit) begin
						nxt.focus = ctsc_pkg::focus_next(nxt.focus);
					end else begin
						do_step = 1'b1;
						step_up = 1'b1;
					end
					changed = 1'b1;
				end
				ctsc_pkg::KEY_DN: begin
					if (!st.edit) begin
						nxt.focus = ctsc_pkg::focus_prev(nxt.focus);
					end else begin
						do_step = 1'b1;
					end
					changed = 1'b1;
				end
				ctsc_pkg::KEY_OK: begin
					// OK on the loading tick is swallowed
					if (!st.first) begin
						if (!st.edit) begin
							nxt.edit = 1'b1;
						end else begin
							nxt.edit  = 1'b0;
							nxt.focus = ctsc_pkg::focus_next(nxt.focus);
						end
					end
					changed = 1'b1;
				end
				ctsc_pkg::KEY_ESC: begin
					if (st.edit) begin
						nxt.edit = 1'b0;
						changed  = 1'b1;
					end else begin
						commit = 1'b1;
					end
				end
				default: ;
			endcase

			if (commit) begin
				// a commit beat never redraws, even on the loading tick
				redraw       = 1'b0;
				nxt.focus    = ctsc_pkg::FLD_YEAR;
				nxt.edit     = 1'b0;
				nxt.first    = 1'b1;
				nxt.blink_on = 1'b1;
				nxt.count    = 8'd0;
			end else begin
				if (nxt.edit) begin
					if (st.count < cfg.blink_limit) begin
						nxt.count = st.count + 8'd1;
					end else begin
						nxt.blink_on = ~st.blink_on;
						nxt.count    = 8'd0;
						redraw       = 1'b1;
					end
				end else begin
					nxt.blink_on = 1'b1;
				end

				unique case (nxt.focus)
					ctsc_pkg::FLD_YEAR: begin
						cur_val = nxt.tf.year;
						mn      = cfg.year_min;
						mx      = cfg.year_max;
					end
					ctsc_pkg::FLD_MONTH: begin
						cur_val = {8'd0, nxt.tf.month};
						mn      = ctsc_pkg::MONTH_MIN;
						mx      = ctsc_pkg::MONTH_MAX;
					end
					ctsc_pkg::FLD_DAY: begin
						cur_val = {7'd0, nxt.tf.day};
						mn      = ctsc_pkg::DAY_MIN;
						mx      = ctsc_pkg::DAY_MAX;
					end
					ctsc_pkg::FLD_HOUR: begin
						cur_val = {7'd0, nxt.tf.hour};
						mn      = ctsc_pkg::HOUR_MIN;
						mx      = ctsc_pkg::HOUR_MAX;
					end
					ctsc_pkg::FLD_MINUTE: begin
						cur_val = {6'd0, nxt.tf.minute};
						mn      = ctsc_pkg::MINSEC_MIN;
						mx      = ctsc_pkg::MINSEC_MAX;
					end
					ctsc_pkg::FLD_SECOND: begin
						cur_val = {6'd0, nxt.tf.second};
						mn      = ctsc_pkg::MINSEC_MIN;
						mx      = ctsc_pkg::MINSEC_MAX;
					end
					default: ;
				endcase

				stepped = ctsc_pkg::step_val(cur_val, mn, mx, step_up);

				if (do_step) begin
					unique case (nxt.focus)
						ctsc_pkg::FLD_YEAR:   nxt.tf.year   = stepped;
						ctsc_pkg::FLD_MONTH:  nxt.tf.month  = stepped[3:0];
						ctsc_pkg::FLD_DAY:    nxt.tf.day    = stepped[4:0];
						ctsc_pkg::FLD_HOUR:   nxt.tf.hour   = stepped[4:0];
						ctsc_pkg::FLD_MINUTE: nxt.tf.minute = stepped[5:0];
						ctsc_pkg::FLD_SECOND: nxt.tf.second = stepped[5:0];
						default: ;
					endcase
					redraw = 1'b1;
				end

				if (changed) begin
					redraw = 1'b1;
				end
				nxt.first = 1'b0;
			end
		end
	end

	always_comb begin
		res.tf             = nxt.tf;
		res.selected_field = nxt.focus;
		res.editing        = nxt.edit;
		res.highlight_on   = ~nxt.edit | nxt.blink_on;
		res.redraw         = redraw;
		res.commit         = commit;
	end

endmodule

// ===== rtl/clock_time_set_controller.sv =====
// Top level of the clock time-set controller: tick input register, state, result register, APB.
// Depends on ctsc_pkg and ctsc_step.
// A tick is held in the tick stage; its result enters the result register once that is free.
// Throughput: one tick per cycle while out_ready is high; one pass over the state registers.
// Reset: arst_n clears both stages, the state (fields zero, focus year, load pending,
// blink on) and the registers to blink_limit 50, year_min 2000, year_max 2099.
`timescale 1ns / 1ps

module clock_time_set_controller (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ctsc_pkg::ADDR_W-1:0]   paddr,
	input  logic [ctsc_pkg::DATA_W-1:0]   pwdata,
	output logic [ctsc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          page_active,
	input  logic [2:0]                    kind,
	input  logic [11:0]                   rtc_year,
	input  logic [3:0]                    rtc_month,
	input  logic [4:0]                    rtc_day,
	input  logic [4:0]                    rtc_hour,
	input  logic [5:0]                    rtc_minute,
	input  logic [5:0]                    rtc_second,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [11:0]                   year,
	output logic [3:0]                    month,
	output logic [4:0]                    day,
	output logic [4:0]                    hour,
	output logic [5:0]                    minute,
	output logic [5:0]                    second,
	output logic [2:0]                    selected_field,
	output logic                          editing,
	output logic                          highlight_on,
	output logic                          redraw,
	output logic                          commit
);

	ctsc_pkg::cfg_t    cfg_q;
	ctsc_pkg::state_t  st_q;
	ctsc_pkg::state_t  st_nxt;
	ctsc_pkg::tick_t   tick_s1;
	ctsc_pkg::result_t res_nxt;
	ctsc_pkg::result_t res_q;
	logic              valid_s1;
	logic              out_valid_q;
	logic              adv;
	logic              cfg_wr;
	logic [1:0]        reg_idx;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_limit <= ctsc_pkg::BLINK_LIMIT_RST;
			cfg_q.year_min    <= ctsc_pkg::YEAR_MIN_RST;
			cfg_q.year_max    <= ctsc_pkg::YEAR_MAX_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				ctsc_pkg::REG_BLINK_LIMIT: cfg_q.blink_limit <= pwdata[7:0];
				ctsc_pkg::REG_YEAR_MIN:    cfg_q.year_min    <= pwdata[11:0];
				ctsc_pkg::REG_YEAR_MAX:    cfg_q.year_max    <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ctsc_pkg::REG_BLINK_LIMIT: prdata = {24'd0, cfg_q.blink_limit};
			ctsc_pkg::REG_YEAR_MIN:    prdata = {20'd0, cfg_q.year_min};
			ctsc_pkg::REG_YEAR_MAX:    prdata = {20'd0, cfg_q.year_max};
			default:                   prdata = '0;
		endcase
	end

	// Pipeline handshake: the tick stage moves on whenever the result register is free
	assign adv      = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1.page_active <= page_active;
			tick_s1.kind        <= kind;
			tick_s1.rtc.year    <= rtc_year;
			tick_s1.rtc.month   <= rtc_month;
			tick_s1.rtc.day     <= rtc_day;
			tick_s1.rtc.hour    <= rtc_hour;
			tick_s1.rtc.minute  <= rtc_minute;
			tick_s1.rtc.second  <= rtc_second;
		end
	end

	ctsc_step u_step (
		.st   (st_q),
		.tick (tick_s1),
		.cfg  (cfg_q),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ctsc_pkg::STATE_RST;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign year           = res_q.tf.year;
	assign month          = res_q.tf.month;
	assign day            = res_q.tf.day;
	assign hour           = res_q.tf.hour;
	assign minute         = res_q.tf.minute;
	assign second         = res_q.tf.second;
	assign selected_field = res_q.selected_field;
	assign editing        = res_q.editing;
	assign highlight_on   = res_q.highlight_on;
	assign redraw         = res_q.redraw;
	assign commit         = res_q.commit;

	a_commit_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.commit |->
			!res_q.editing && !res_q.redraw && res_q.selected_field == ctsc_pkg::FLD_YEAR)
		else $error("commit beat with edit state or redraw");

	a_commit_rearms_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_nxt.commit |=> st_q.first && !st_q.edit)
		else $error("commit did not re-arm the clock load");

	a_focus_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.focus <= ctsc_pkg::FLD_SECOND)
		else $error("field focus out of range");

	a_select_highlight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.editing |-> res_q.highlight_on)
		else $error("highlight off in select mode");

	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> st_q == $past(st_q))
		else $error("state changed without a tick beat");

endmodule

// ===== sim/clock_time_set_controller_tb.sv =====
// Self-checking testbench for the clock time-set controller: directed table, then random
// UI tick sessions under several register settings, checked against a built-in predictor.
// Depends on ctsc_pkg and the clock_time_set_controller RTL.
`timescale 1ns / 1ps

module clock_time_set_controller_tb;

	localparam int CLK_HALF     = 5;
	localparam int PHASE_TICKS  = 205;
	localparam int NUM_PHASES   = 7;
	localparam int HOLD_CYCLES  = 64;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 6;

	// Key codes with no action
	localparam logic [2:0] KEY_RSVD_LO = 3'd5;
	localparam logic [2:0] KEY_RSVD_HI = 3'd7;

	// Receiver stall patterns
	localparam int RX_FREE    = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;
	localparam int RX_SLOW    = 3;

	typedef struct packed {
		logic            act;
		logic [2:0]      key;
		ctsc_pkg::time_t rtc;
	} ui_tick_t;

	typedef struct {
		ui_tick_t          t;
		bit                typed;
		ctsc_pkg::result_t want;
	} dir_row_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          psel        = 1'b0;
	logic                          penable     = 1'b0;
	logic                          pwrite      = 1'b0;
	logic [ctsc_pkg::ADDR_W-1:0]   paddr       = '0;
	logic [ctsc_pkg::DATA_W-1:0]   pwdata      = '0;
	logic [ctsc_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid    = 1'b0;
	logic                          in_ready;
	logic                          page_active = 1'b0;
	logic [2:0]                    kind        = ctsc_pkg::KEY_NONE;
	logic [11:0]                   rtc_year    = '0;
	logic [3:0]                    rtc_month   = '0;
	logic [4:0]                    rtc_day     = '0;
	logic [4:0]                    rtc_hour    = '0;
	logic [5:0]                    rtc_minute  = '0;
	logic [5:0]                    rtc_second  = '0;
	logic                          out_valid;
	logic                          out_ready   = 1'b0;
	logic [11:0]                   year;
	logic [3:0]                    month;
	logic [4:0]                    day;
	logic [4:0]                    hour;
	logic [5:0]                    minute;
	logic [5:0]                    second;
	logic [2:0]                    selected_field;
	logic                          editing;
	logic                          highlight_on;
	logic                          redraw;
	logic                          commit;

	// Predictor state and its copy of the registers
	logic [11:0] fld_val [6];
	logic [2:0]  cur_focus;
	logic        in_edit;
	logic        reload_due;
	logic        blink_phase;
	logic [7:0]  blink_ticks;
	logic [7:0]  lim_blink;
	logic [11:0] lim_ymin;
	logic [11:0] lim_ymax;

	ctsc_pkg::result_t screen_q [$];
	dir_row_t          dir_tab [$];

	int  n_mism     = 0;
	int  n_ticks    = 0;
	int  n_checked  = 0;
	int  n_commits  = 0;
	int  n_blinks   = 0;
	int  n_settings = 1;
	int  quiet      = 0;
	int  rx_mode    = RX_RANDOM;
	int  rx_cnt     = 0;
	int  back_pct   = 6;
	bit  gaps_on    = 1'b1;
	bit  hold_req   = 1'b0;

	clock_time_set_controller u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.page_active    (page_active),
		.kind           (kind),
		.rtc_year       (rtc_year),
		.rtc_month      (rtc_month),
		.rtc_day        (rtc_day),
		.rtc_hour       (rtc_hour),
		.rtc_minute     (rtc_minute),
		.rtc_second     (rtc_second),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.year           (year),
		.month          (month),
		.day            (day),
		.hour           (hour),
		.minute         (minute),
		.second         (second),
		.selected_field (selected_field),
		.editing        (editing),
		.highlight_on   (highlight_on),
		.redraw         (redraw),
		.commit         (commit)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic ctsc_pkg::result_t show_screen(input logic rd, input logic cm);
		ctsc_pkg::result_t r;
		r.tf.year        = fld_val[ctsc_pkg::FLD_YEAR];
		r.tf.month       = fld_val[ctsc_pkg::FLD_MONTH][3:0];
		r.tf.day         = fld_val[ctsc_pkg::FLD_DAY][4:0];
		r.tf.hour        = fld_val[ctsc_pkg::FLD_HOUR][4:0];
		r.tf.minute      = fld_val[ctsc_pkg::FLD_MINUTE][5:0];
		r.tf.second      = fld_val[ctsc_pkg::FLD_SECOND][5:0];
		r.selected_field = cur_focus;
		r.editing        = in_edit;
		r.highlight_on   = !in_edit || blink_phase;
		r.redraw         = rd;
		r.commit         = cm;
		return r;
	endfunction

	// Advance the predictor by one tick and return the screen it should produce
	function automatic ctsc_pkg::result_t next_screen(input ui_tick_t t);
		logic        show;
		logic        step_up;
		logic        step_dn;
		logic [11:0] lo;
		logic [11:0] hi;
		logic [11:0] v;
		show    = 1'b0;
		step_up = 1'b0;
		step_dn = 1'b0;
		if (!t.act)
			return show_screen(1'b0, 1'b0);
		if (reload_due) begin
			fld_val[ctsc_pkg::FLD_YEAR]   = t.rtc.year;
			fld_val[ctsc_pkg::FLD_MONTH]  = {8'd0, t.rtc.month};
			fld_val[ctsc_pkg::FLD_DAY]    = {7'd0, t.rtc.day};
			fld_val[ctsc_pkg::FLD_HOUR]   = {7'd0, t.rtc.hour};
			fld_val[ctsc_pkg::FLD_MINUTE] = {6'd0, t.rtc.minute};
			fld_val[ctsc_pkg::FLD_SECOND] = {6'd0, t.rtc.second};
			cur_focus = ctsc_pkg::FLD_YEAR;
			show = 1'b1;
		end
		case (t.key)
			ctsc_pkg::KEY_UP: begin
				if (!in_edit)
					cur_focus = (cur_focus >= ctsc_pkg::FLD_SECOND) ?
						ctsc_pkg::FLD_YEAR : cur_focus + 3'd1;
				else
					step_up = 1'b1;
				show = 1'b1;
			end
			ctsc_pkg::KEY_DN: begin
				if (!in_edit)
					cur_focus = (cur_focus == ctsc_pkg::FLD_YEAR) ?
						ctsc_pkg::FLD_SECOND : cur_focus - 3'd1;
				else
					step_dn = 1'b1;
				show = 1'b1;
			end
			ctsc_pkg::KEY_OK: begin
				// the load tick swallows OK
				if (!reload_due) begin
					if (!in_edit) begin
						in_edit = 1'b1;
					end else begin
						in_edit = 1'b0;
						cur_focus = (cur_focus >= ctsc_pkg::FLD_SECOND) ?
							ctsc_pkg::FLD_YEAR : cur_focus + 3'd1;
					end
				end
				show = 1'b1;
			end
			ctsc_pkg::KEY_ESC: begin
				if (in_edit) begin
					in_edit = 1'b0;
					show = 1'b1;
				end else begin
					cur_focus   = ctsc_pkg::FLD_YEAR;
					reload_due  = 1'b1;
					blink_phase = 1'b1;
					blink_ticks = 8'd0;
					return show_screen(1'b0, 1'b1);
				end
			end
			default: ;
		endcase
		if (in_edit) begin
			if (blink_ticks < lim_blink) begin
				blink_ticks = blink_ticks + 8'd1;
			end else begin
				blink_phase = !blink_phase;
				blink_ticks = 8'd0;
				show = 1'b1;
				n_blinks++;
			end
		end else begin
			blink_phase = 1'b1;
		end
		if (step_up || step_dn) begin
			case (cur_focus)
				ctsc_pkg::FLD_YEAR: begin
					lo = lim_ymin;
					hi = lim_ymax;
				end
				ctsc_pkg::FLD_MONTH: begin
					lo = ctsc_pkg::MONTH_MIN;
					hi = ctsc_pkg::MONTH_MAX;
				end
				ctsc_pkg::FLD_DAY: begin
					lo = ctsc_pkg::DAY_MIN;
					hi = ctsc_pkg::DAY_MAX;
				end
				ctsc_pkg::FLD_HOUR: begin
					lo = ctsc_pkg::HOUR_MIN;
					hi = ctsc_pkg::HOUR_MAX;
				end
				default: begin
					lo = ctsc_pkg::MINSEC_MIN;
					hi = ctsc_pkg::MINSEC_MAX;
				end
			endcase
			v = fld_val[cur_focus];
			if (step_up)
				v = (v >= hi) ? lo : v + 12'd1;
			else
				v = (v <= lo) ? hi : v - 12'd1;
			fld_val[cur_focus] = v;
			show = 1'b1;
		end
		reload_due = 1'b0;
		return show_screen(show, 1'b0);
	endfunction

	function automatic ui_tick_t rand_tick(input bit dwell);
		ui_tick_t t;
		int       r;
		r = $urandom_range(0, 99);
		t.act = 1'b1;
		if (dwell) begin
			// long runs of stepping so the blink counter gets somewhere
			t.act = (r >= 5);
			t.key = (r < 30) ? ctsc_pkg::KEY_NONE : (r < 65) ? ctsc_pkg::KEY_UP :
				ctsc_pkg::KEY_DN;
		end else if (r < 8) begin
			t.act = 1'b0;
			t.key = 3'($urandom_range(0, 7));
		end else if (r < 14) begin
			t.key = 3'($urandom_range(KEY_RSVD_LO, KEY_RSVD_HI));
		end else if (r < 24) begin
			t.key = ctsc_pkg::KEY_NONE;
		end else if (r < 44) begin
			t.key = ctsc_pkg::KEY_UP;
		end else if (r < 62) begin
			t.key = ctsc_pkg::KEY_DN;
		end else if (r < 100 - back_pct) begin
			t.key = ctsc_pkg::KEY_OK;
		end else begin
			t.key = ctsc_pkg::KEY_ESC;
		end
		if ($urandom_range(0, 1)) begin
			t.rtc.year   = 12'($urandom_range(0, 4095));
			t.rtc.month  = 4'($urandom_range(0, 15));
			t.rtc.day    = 5'($urandom_range(0, 31));
			t.rtc.hour   = 5'($urandom_range(0, 31));
			t.rtc.minute = 6'($urandom_range(0, 63));
			t.rtc.second = 6'($urandom_range(0, 63));
		end else begin
			t.rtc.year   = 12'($urandom_range(1990, 2110));
			t.rtc.month  = 4'($urandom_range(1, 12));
			t.rtc.day    = 5'($urandom_range(1, 31));
			t.rtc.hour   = 5'($urandom_range(0, 23));
			t.rtc.minute = 6'($urandom_range(0, 59));
			t.rtc.second = 6'($urandom_range(0, 59));
		end
		return t;
	endfunction

	task automatic add_row(input logic act, input logic [2:0] key, input ctsc_pkg::time_t rtc,
		input bit typed, input ctsc_pkg::result_t want);
		dir_row_t row;
		row.t.act = act;
		row.t.key = key;
		row.t.rtc = rtc;
		row.typed = typed;
		row.want  = want;
		dir_tab.push_back(row);
	endtask

	// Offer one tick beat, hold it until accepted, then log what it should produce
	task automatic offer_tick(input ui_tick_t t, input bit typed,
		input ctsc_pkg::result_t want);
		ctsc_pkg::result_t p;
		in_valid    <= 1'b1;
		page_active <= t.act;
		kind        <= t.key;
		rtc_year    <= t.rtc.year;
		rtc_month   <= t.rtc.month;
		rtc_day     <= t.rtc.day;
		rtc_hour    <= t.rtc.hour;
		rtc_minute  <= t.rtc.minute;
		rtc_second  <= t.rtc.second;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		p = next_screen(t);
		screen_q.push_back(typed ? want : p);
		n_ticks++;
	endtask

	task automatic run_session(input int n);
		int burst_left;
		bit dwell;
		burst_left = 0;
		dwell = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				dwell = ($urandom_range(0, 3) == 0);
				if (gaps_on && $urandom_range(0, 3) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
			offer_tick(rand_tick(dwell), 1'b0, '0);
			burst_left--;
		end
	endtask

	task automatic drain_screens();
		in_valid <= 1'b0;
		while (screen_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_cycle(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] rd;
		apb_cycle(1'b1, idx, val, rd);
		apb_cycle(1'b0, idx, '0, rd);
		if (rd !== val) begin
			$error("register %0d readback: expected %0d, got %0d", idx, val, rd);
			n_mism++;
		end
		case (idx)
			ctsc_pkg::REG_BLINK_LIMIT: lim_blink = val[7:0];
			ctsc_pkg::REG_YEAR_MIN:    lim_ymin  = val[11:0];
			default:                   lim_ymax  = val[11:0];
		endcase
	endtask

	task automatic set_limits(input int ph);
		logic [7:0]  b;
		logic [11:0] lo;
		logic [11:0] hi;
		case (ph)
			1:       begin b = 8'd1;   lo = 12'd0;    hi = 12'd4095; end
			2:       begin b = 8'd0;   lo = 12'd4095; hi = 12'd0;    end
			3:       begin b = 8'd255; lo = 12'd2000; hi = 12'd2099; end
			4:       begin b = 8'd2;   lo = 12'd2010; hi = 12'd2005; end
			5:       begin b = 8'd8;   lo = 12'd1995; hi = 12'd2003; end
			default: begin
				b  = 8'($urandom_range(0, 255));
				lo = 12'($urandom_range(0, 4095));
				hi = 12'($urandom_range(0, 4095));
			end
		endcase
		reg_write(ctsc_pkg::REG_BLINK_LIMIT, {24'd0, b});
		reg_write(ctsc_pkg::REG_YEAR_MIN, {20'd0, lo});
		reg_write(ctsc_pkg::REG_YEAR_MAX, {20'd0, hi});
		n_settings++;
	endtask

	task automatic check_field(input string name, input logic [11:0] want,
		input logic [11:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_mism++;
		end
	endtask

	always @(posedge clk) begin : result_mon
		ctsc_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (screen_q.size() == 0) begin
				$error("result beat with nothing expected");
				n_mism++;
			end else begin
				want = screen_q.pop_front();
				check_field("year", want.tf.year, year);
				check_field("month", 12'(want.tf.month), 12'(month));
				check_field("day", 12'(want.tf.day), 12'(day));
				check_field("hour", 12'(want.tf.hour), 12'(hour));
				check_field("minute", 12'(want.tf.minute), 12'(minute));
				check_field("second", 12'(want.tf.second), 12'(second));
				check_field("selected_field", 12'(want.selected_field),
					12'(selected_field));
				check_field("editing", 12'(want.editing), 12'(editing));
				check_field("highlight_on", 12'(want.highlight_on), 12'(highlight_on));
				check_field("redraw", 12'(want.redraw), 12'(redraw));
				check_field("commit", 12'(want.commit), 12'(commit));
				n_checked++;
				if (commit)
					n_commits++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("clock_time_set_controller verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// hold off long enough to back the block up into its input
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				rx_cnt++;
				case (rx_mode)
					RX_FREE:    out_ready <= 1'b1;
					RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
					RX_PATTERN: out_ready <= ((rx_cnt % 7) < 4);
					default:    out_ready <= ($urandom_range(0, 2) == 0);
				endcase
			end
		end
	end

	initial begin : stim
		ctsc_pkg::time_t rtc_top;
		ctsc_pkg::time_t rtc_zero;
		ctsc_pkg::time_t rtc_ones;
		rtc_top  = {12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59};
		rtc_zero = '0;
		rtc_ones = '1;
		foreach (fld_val[i])
			fld_val[i] = '0;
		cur_focus   = ctsc_pkg::FLD_YEAR;
		in_edit     = 1'b0;
		reload_due  = 1'b1;
		blink_phase = 1'b1;
		blink_ticks = 8'd0;
		lim_blink   = ctsc_pkg::BLINK_LIMIT_RST;
		lim_ymin    = ctsc_pkg::YEAR_MIN_RST;
		lim_ymax    = ctsc_pkg::YEAR_MAX_RST;

		// want columns: year month day hour minute second | focus editing highlight redraw commit
		add_row(1'b0, ctsc_pkg::KEY_UP, rtc_ones, 1'b1,
			{12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, ctsc_pkg::FLD_YEAR, 1'b0, 1'b1, 1'b0, 1'b0});
		add_row(1'b1, ctsc_pkg::KEY_OK, rtc_top, 1'b1,
			{rtc_top, ctsc_pkg::FLD_YEAR, 1'b0, 1'b1, 1'b1, 1'b0});
		add_row(1'b1, ctsc_pkg::KEY_OK, rtc_zero, 1'b1,
			{rtc_top, ctsc_pkg::FLD_YEAR, 1'b1, 1'b1, 1'b1, 1'b0});
		add_row(1'b1, ctsc_pkg::KEY_UP, rtc_zero, 1'b1,
			{12'd2000, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, ctsc_pkg::FLD_YEAR,
			1'b1, 1'b1, 1'b1, 1'b0});
		add_row(1'b1, ctsc_pkg::KEY_DN, rtc_zero, 1'b1,
			{rtc_top, ctsc_pkg::FLD_YEAR, 1'b1, 1'b1, 1'b1, 1'b0});
		add_row(1'b1, ctsc_pkg::KEY_NONE, rtc_zero, 1'b1,
			{rtc_top, ctsc_pkg::FLD_YEAR, 1'b1, 1'b1, 1'b0, 1'b0});
		add_row(1'b0, ctsc_pkg::KEY_ESC, rtc_zero, 1'b1,
			{rtc_top, ctsc_pkg::FLD_YEAR, 1'b1, 1'b1, 1'b0, 1'b0});
		add_row(1'b1, KEY_RSVD_HI, rtc_zero, 1'b1,
			{rtc_top, ctsc_pkg::FLD_YEAR, 1'b1, 1'b1, 1'b0, 1'b0});
		add_row(1'b1, ctsc_pkg::KEY_OK, rtc_zero, 1'b1,
			{rtc_top, ctsc_pkg::FLD_MONTH, 1'b0, 1'b1, 1'b1, 1'b0});
		add_row(1'b1, ctsc_pkg::KEY_OK, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_UP, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_ESC, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_DN, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_DN, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_UP, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_ESC, rtc_zero, 1'b1,
			{12'd2099, 4'd1, 5'd31, 5'd23, 6'd59, 6'd59, ctsc_pkg::FLD_YEAR,
			1'b0, 1'b1, 1'b0, 1'b1});
		// ESC on the load tick commits straight away
		add_row(1'b1, ctsc_pkg::KEY_ESC, rtc_zero, 1'b1,
			{rtc_zero, ctsc_pkg::FLD_YEAR, 1'b0, 1'b1, 1'b0, 1'b1});
		add_row(1'b1, ctsc_pkg::KEY_UP, rtc_ones, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_OK, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_UP, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_DN, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_OK, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_UP, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_OK, rtc_zero, 1'b0, '0);
		add_row(1'b1, ctsc_pkg::KEY_DN, rtc_zero, 1'b0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			offer_tick(dir_tab[i].t, dir_tab[i].typed, dir_tab[i].want);
		run_session(PHASE_TICKS);

		for (int ph = 1; ph < NUM_PHASES; ph++) begin
			drain_screens();
			set_limits(ph);
			rx_mode  = (ph == 1) ? RX_FREE : 1 + (ph % 3);
			gaps_on  = (ph != 1);
			back_pct = (ph == 3) ? 1 : 6;
			if (ph == 2)
				hold_req = 1'b1;
			run_session(PHASE_TICKS);
		end
		drain_screens();

		$display("%0d tick beats over %0d register settings, %0d results checked",
			n_ticks, n_settings, n_checked);
		$display("%0d commits and %0d blink toggles exercised", n_commits, n_blinks);
		if (n_mism == 0) begin
			$display("clock_time_set_controller verification clean");
		end else begin
			$display("clock_time_set_controller verification failed");
		end
		$finish;
	end

endmodule
